[hdl/wpbm_pkg.sv]
// wpbm_pkg: shared types and constants for the pipelined bus master
// no dependencies; used by wpbm_ctrl, wpbm_dp, the top level and the bench

package wpbm_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request and start the queue read
    logic commit;   // apply the request and load the result register
  } cmd_t;

endpackage

[hdl/wpbm_in_if.sv]
// wpbm_in_if: request channel of the bus master (valid, ready, request fields)
// depends on nothing

interface wpbm_in_if #(
  parameter int ADDR_WIDTH = 32,
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic                  cmd_write;
  logic [ADDR_WIDTH-1:0] cmd_addr;
  logic [DATA_WIDTH-1:0] cmd_wdata;
  logic                  bus_ack_in;
  logic                  bus_stall_in;
  logic [DATA_WIDTH-1:0] bus_rdata_in;

  modport source (
    output valid, req_type, cmd_write, cmd_addr, cmd_wdata,
           bus_ack_in, bus_stall_in, bus_rdata_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, cmd_write, cmd_addr, cmd_wdata,
           bus_ack_in, bus_stall_in, bus_rdata_in,
    output ready
  );
endinterface

[hdl/wpbm_out_if.sv]
// wpbm_out_if: result channel of the bus master (valid, ready, bus and status fields)
// depends on nothing

interface wpbm_out_if #(
  parameter int ADDR_WIDTH = 32,
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  bus_cyc;
  logic                  bus_stb;
  logic                  bus_we;
  logic [ADDR_WIDTH-1:0] bus_addr;
  logic [DATA_WIDTH-1:0] bus_wdata;
  logic                  rd_valid;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  busy_res;
  logic                  cmd_dropped;

  modport source (
    output valid, bus_cyc, bus_stb, bus_we, bus_addr, bus_wdata,
           rd_valid, rd_data, busy_res, cmd_dropped,
    input  ready
  );

  modport sink (
    input  valid, bus_cyc, bus_stb, bus_we, bus_addr, bus_wdata,
           rd_valid, rd_data, busy_res, cmd_dropped,
    output ready
  );
endinterface

[hdl/wishbone_pipelined_bus_master.sv]
// wishbone_pipelined_bus_master: top level of the pipelined bus master
// depends on wpbm_pkg, wpbm_in_if, wpbm_out_if, wpbm_ctrl, wpbm_dp

// Pipelined bus master with a command queue. Each request on in_ch is an
// enqueue (read or write with address and data), a bus tick (slave ack,
// stall and read data of a bus clock) or a clear of both queues.
// Every request yields exactly one result on out_ch: the bus cyc, stb, we,
// address and write data after the request, read data with rd_valid when a
// read ack arrived on that tick, busy_res while commands are queued or acks
// outstanding, and cmd_dropped when an enqueue found the queue or the ack list
// full. In ST_IDLE a request is captured and the queue head read from the
// command ram (registered read); in ST_EXEC it is applied and the result
// register loaded, so no new request is taken until ST_EXEC ends. The result
// register decouples the two channels; a stalled result holds ST_EXEC until
// the sink takes the previous one. Queue storage is QUEUE_DEPTH entries in
// ram; unwritten entries are never read, so no clearing pass is needed.

module wishbone_pipelined_bus_master #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_WIDTH  = 32,
  parameter int DATA_WIDTH  = 32
) (
  input logic        clk,
  input logic        rst_n,
  wpbm_in_if.sink    in_ch,
  wpbm_out_if.source out_ch
);

  wpbm_pkg::cmd_t cmd;

  // request sequencing and result handshake
  wpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // bus registers, queues and result payload
  wpbm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_req_type   (in_ch.req_type),
    .in_cmd_write  (in_ch.cmd_write),
    .in_cmd_addr   (in_ch.cmd_addr),
    .in_cmd_wdata  (in_ch.cmd_wdata),
    .in_bus_ack    (in_ch.bus_ack_in),
    .in_bus_stall  (in_ch.bus_stall_in),
    .in_bus_rdata  (in_ch.bus_rdata_in),
    .out_bus_cyc   (out_ch.bus_cyc),
    .out_bus_stb   (out_ch.bus_stb),
    .out_bus_we    (out_ch.bus_we),
    .out_bus_addr  (out_ch.bus_addr),
    .out_bus_wdata (out_ch.bus_wdata),
    .out_rd_valid  (out_ch.rd_valid),
    .out_rd_data   (out_ch.rd_data),
    .out_busy      (out_ch.busy_res),
    .out_dropped   (out_ch.cmd_dropped)
  );

endmodule

[hdl/wpbm_ram.sv]
// wpbm_ram: generic single write port, single read port ram with registered read
// no dependencies

module wpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/wpbm_ctrl.sv]
// wpbm_ctrl: request sequencer and result valid flag of the bus master
// depends on wpbm_pkg

module wpbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output wpbm_pkg::cmd_t cmd
);

  wpbm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpbm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      wpbm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = wpbm_pkg::ST_EXEC;
        end
      end
      wpbm_pkg::ST_EXEC: begin
        // wait for a free result slot
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = wpbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wpbm_pkg::ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/wpbm_dp.sv]
// wpbm_dp: bus registers, command queue, outstanding-ack list and result register
// depends on wpbm_pkg and wpbm_ram

module wpbm_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_WIDTH  = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wpbm_pkg::cmd_t        cmd,
  input  logic [1:0]            in_req_type,
  input  logic                  in_cmd_write,
  input  logic [ADDR_WIDTH-1:0] in_cmd_addr,
  input  logic [DATA_WIDTH-1:0] in_cmd_wdata,
  input  logic                  in_bus_ack,
  input  logic                  in_bus_stall,
  input  logic [DATA_WIDTH-1:0] in_bus_rdata,
  output logic                  out_bus_cyc,
  output logic                  out_bus_stb,
  output logic                  out_bus_we,
  output logic [ADDR_WIDTH-1:0] out_bus_addr,
  output logic [DATA_WIDTH-1:0] out_bus_wdata,
  output logic                  out_rd_valid,
  output logic [DATA_WIDTH-1:0] out_rd_data,
  output logic                  out_busy,
  output logic                  out_dropped
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = 1 + ADDR_WIDTH + DATA_WIDTH;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [IW:0]   DEPTH_W  = (IW+1)'(QUEUE_DEPTH);

  // bus and queue pointer state
  logic                  cyc_r, cyc_nxt;
  logic                  stb_r, stb_nxt;
  logic                  we_r, we_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [DATA_WIDTH-1:0] wdata_r, wdata_nxt;
  logic [IW-1:0]         qhead_r, qhead_nxt;
  logic [CW-1:0]         qcount_r, qcount_nxt;
  logic [IW-1:0]         phead_r, phead_nxt;
  logic [CW-1:0]         pcount_r, pcount_nxt;

  // latched request
  logic [1:0]            req_r;
  logic                  write_r;
  logic [ADDR_WIDTH-1:0] caddr_r;
  logic [DATA_WIDTH-1:0] cwdata_r;
  logic                  ack_r;
  logic                  stall_r;
  logic [DATA_WIDTH-1:0] rdata_r;

  // result register
  logic                  res_rd_valid_r, res_rd_valid_nxt;
  logic [DATA_WIDTH-1:0] res_rd_data_r, res_rd_data_nxt;
  logic                  res_busy_r;
  logic                  res_dropped_r, res_dropped_nxt;

  // queue memories
  logic [IW-1:0] q_rd_addr, q_wr_addr, p_wr_addr;
  logic [EW-1:0] q_rd_data;
  logic          p_rd_data;
  logic          enq_wr;
  logic          full;
  logic          retire_now;
  logic [IW:0]   qsum, psum;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // head that the tick will present, known before the tick is applied
  assign retire_now = cyc_r && stb_r && !in_bus_stall;
  assign q_rd_addr  = (retire_now && qcount_r != '0) ? ring_next(qhead_r) : qhead_r;

  // tail positions, wrapped by one compare and subtract
  assign qsum      = (IW+1)'(qhead_r) + (IW+1)'(qcount_r);
  assign psum      = (IW+1)'(phead_r) + (IW+1)'(pcount_r);
  assign q_wr_addr = (qsum >= DEPTH_W) ? IW'(qsum - DEPTH_W) : IW'(qsum);
  assign p_wr_addr = (psum >= DEPTH_W) ? IW'(psum - DEPTH_W) : IW'(psum);

  assign full   = (qcount_r == FULL_CNT) || (pcount_r == FULL_CNT);
  assign enq_wr = cmd.commit && (req_r == wpbm_pkg::REQ_ENQUEUE) && !full;

  wpbm_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk     (clk),
    .wr_en   (enq_wr),
    .wr_addr (q_wr_addr),
    .wr_data ({write_r, caddr_r, cwdata_r}),
    .rd_en   (cmd.capture),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  wpbm_ram #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_ack_ram (
    .clk     (clk),
    .wr_en   (enq_wr),
    .wr_addr (p_wr_addr),
    .wr_data (write_r),
    .rd_en   (cmd.capture),
    .rd_addr (phead_r),
    .rd_data (p_rd_data)
  );

  always_comb begin
    cyc_nxt          = cyc_r;
    stb_nxt          = stb_r;
    we_nxt           = we_r;
    addr_nxt         = addr_r;
    wdata_nxt        = wdata_r;
    qhead_nxt        = qhead_r;
    qcount_nxt       = qcount_r;
    phead_nxt        = phead_r;
    pcount_nxt       = pcount_r;
    res_rd_valid_nxt = 1'b0;
    res_rd_data_nxt  = '0;
    res_dropped_nxt  = 1'b0;

    case (req_r)
      wpbm_pkg::REQ_ENQUEUE: begin
        if (full) begin
          res_dropped_nxt = 1'b1;
        end else begin
          qcount_nxt = qcount_r + 1'b1;
          pcount_nxt = pcount_r + 1'b1;
        end
      end
      wpbm_pkg::REQ_TICK: begin
        // strobe taken by the slave
        if (cyc_r && stb_r && !stall_r) begin
          if (qcount_r != '0) begin
            qhead_nxt  = ring_next(qhead_r);
            qcount_nxt = qcount_r - 1'b1;
          end
          stb_nxt = 1'b0;
          we_nxt  = 1'b0;
          if (pcount_r == '0) begin
            cyc_nxt = 1'b0;
          end
        end
        // present the next queued request
        if (qcount_nxt != '0) begin
          cyc_nxt   = 1'b1;
          stb_nxt   = 1'b1;
          we_nxt    = q_rd_data[EW-1];
          addr_nxt  = q_rd_data[EW-2 -: ADDR_WIDTH];
          wdata_nxt = q_rd_data[DATA_WIDTH-1:0];
        end
        // acknowledge
        if (cyc_nxt && ack_r && pcount_r != '0) begin
          if (!p_rd_data) begin
            res_rd_valid_nxt = 1'b1;
            res_rd_data_nxt  = rdata_r;
          end
          phead_nxt  = ring_next(phead_r);
          pcount_nxt = pcount_r - 1'b1;
          if (pcount_nxt == '0) begin
            cyc_nxt = 1'b0;
          end
        end
      end
      wpbm_pkg::REQ_CLEAR: begin
        qhead_nxt  = '0;
        qcount_nxt = '0;
        phead_nxt  = '0;
        pcount_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r    <= 1'b0;
      stb_r    <= 1'b0;
      we_r     <= 1'b0;
      addr_r   <= '0;
      wdata_r  <= '0;
      qhead_r  <= '0;
      qcount_r <= '0;
      phead_r  <= '0;
      pcount_r <= '0;
    end else if (cmd.commit) begin
      cyc_r    <= cyc_nxt;
      stb_r    <= stb_nxt;
      we_r     <= we_nxt;
      addr_r   <= addr_nxt;
      wdata_r  <= wdata_nxt;
      qhead_r  <= qhead_nxt;
      qcount_r <= qcount_nxt;
      phead_r  <= phead_nxt;
      pcount_r <= pcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req_type;
      write_r  <= in_cmd_write;
      caddr_r  <= in_cmd_addr;
      cwdata_r <= in_cmd_wdata;
      ack_r    <= in_bus_ack;
      stall_r  <= in_bus_stall;
      rdata_r  <= in_bus_rdata;
    end
    if (cmd.commit) begin
      res_rd_valid_r <= res_rd_valid_nxt;
      res_rd_data_r  <= res_rd_data_nxt;
      res_busy_r     <= (qcount_nxt != '0) || (pcount_nxt != '0);
      res_dropped_r  <= res_dropped_nxt;
    end
  end

  // bus fields of the result mirror the bus registers after the request
  assign out_bus_cyc   = cyc_r;
  assign out_bus_stb   = stb_r;
  assign out_bus_we    = we_r;
  assign out_bus_addr  = addr_r;
  assign out_bus_wdata = wdata_r;
  assign out_rd_valid  = res_rd_valid_r;
  assign out_rd_data   = res_rd_data_r;
  assign out_busy      = res_busy_r;
  assign out_dropped   = res_dropped_r;

endmodule

[sim/wishbone_pipelined_bus_master_tb.sv]
// wishbone_pipelined_bus_master_tb: self-checking bench that predicts the bus and status result
// of every request and compares it against out_ch; needs wpbm_pkg, wpbm_in_if, wpbm_out_if
// and the wishbone_pipelined_bus_master rtl

module wishbone_pipelined_bus_master_tb;

  localparam int CLK_PERIOD = 8;
  localparam int QDEPTH     = 16;
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int MAX_CYCLES = 200000;
  localparam int TAIL_WAIT  = 12;
  localparam int PRINT_CAP  = 100;

  // the fourth request code has no meaning in the block, it only reports status
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        req_type;
    logic              cmd_write;
    logic [ADDR_W-1:0] cmd_addr;
    logic [DATA_W-1:0] cmd_wdata;
    logic              ack;
    logic              stall;
    logic [DATA_W-1:0] rdata;
  } bus_req_t;

  typedef struct {
    logic              cyc;
    logic              stb;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic              rd_valid;
    logic [DATA_W-1:0] rd_data;
    logic              busy;
    logic              dropped;
  } bus_status_t;

  logic clk;
  logic rst_n;

  wpbm_in_if  #(.ADDR_WIDTH(ADDR_W), .DATA_WIDTH(DATA_W)) in_ch ();
  wpbm_out_if #(.ADDR_WIDTH(ADDR_W), .DATA_WIDTH(DATA_W)) out_ch ();

  wishbone_pipelined_bus_master #(
    .QUEUE_DEPTH(QDEPTH),
    .ADDR_WIDTH (ADDR_W),
    .DATA_WIDTH (DATA_W)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // requests waiting to be driven, and the status results still owed by the block
  bus_req_t    req_backlog[$];
  bus_status_t status_owed[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  error_count;
  int  cycle_count;
  logic req_taken;

  // predicted state of the master: bus registers, command queue and outstanding-ack list
  logic              cyc_q, stb_q, we_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic [ADDR_W-1:0] cmd_addr_mem  [QDEPTH];
  logic [DATA_W-1:0] cmd_wdata_mem [QDEPTH];
  logic              cmd_write_mem [QDEPTH];
  logic              ack_write_mem [QDEPTH];
  int                cmd_head, cmd_count;
  int                ack_head, ack_count;

  // clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // apply one request to the predicted state and return the status the block should report
  function automatic bus_status_t predict_bus_status(bus_req_t r);
    bus_status_t s;
    int          slot;
    s = '{default: '0};
    case (r.req_type)
      wpbm_pkg::REQ_ENQUEUE: begin
        if (cmd_count >= QDEPTH || ack_count >= QDEPTH) begin
          // full queue or full ack list: refused, nothing changes
          s.dropped = 1'b1;
        end else begin
          slot = (cmd_head + cmd_count) % QDEPTH;
          cmd_addr_mem[slot]  = r.cmd_addr;
          cmd_wdata_mem[slot] = r.cmd_wdata;
          cmd_write_mem[slot] = r.cmd_write;
          cmd_count++;
          slot = (ack_head + ack_count) % QDEPTH;
          ack_write_mem[slot] = r.cmd_write;
          ack_count++;
        end
      end
      wpbm_pkg::REQ_TICK: begin
        // strobe taken by the slave: retire the head command (if one is left after a clear)
        if (cyc_q && stb_q && !r.stall) begin
          if (cmd_count > 0) begin
            cmd_head = (cmd_head + 1) % QDEPTH;
            cmd_count--;
          end
          stb_q = 1'b0;
          we_q  = 1'b0;
          if (ack_count == 0) cyc_q = 1'b0;
        end
        // put the next queued command on the bus
        if (cmd_count > 0) begin
          cyc_q   = 1'b1;
          stb_q   = 1'b1;
          we_q    = cmd_write_mem[cmd_head];
          addr_q  = cmd_addr_mem[cmd_head];
          wdata_q = cmd_wdata_mem[cmd_head];
        end
        // acknowledge: stray ones (cyc low or nothing outstanding) are ignored
        if (cyc_q && r.ack && ack_count > 0) begin
          if (!ack_write_mem[ack_head]) begin
            s.rd_valid = 1'b1;
            s.rd_data  = r.rdata;
          end
          ack_head = (ack_head + 1) % QDEPTH;
          ack_count--;
          if (ack_count == 0) cyc_q = 1'b0;
        end
      end
      wpbm_pkg::REQ_CLEAR: begin
        // only the queues empty, bus registers hold until the next tick
        cmd_head  = 0;
        cmd_count = 0;
        ack_head  = 0;
        ack_count = 0;
      end
      default: ;
    endcase
    s.cyc   = cyc_q;
    s.stb   = stb_q;
    s.we    = we_q;
    s.addr  = addr_q;
    s.wdata = wdata_q;
    s.busy  = (cmd_count > 0 || ack_count > 0);
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_CAP) $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // request driver: new values at the falling edge, held until the request is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= req_backlog[0].req_type;
        in_ch.cmd_write    <= req_backlog[0].cmd_write;
        in_ch.cmd_addr     <= req_backlog[0].cmd_addr;
        in_ch.cmd_wdata    <= req_backlog[0].cmd_wdata;
        in_ch.bus_ack_in   <= req_backlog[0].ack;
        in_ch.bus_stall_in <= req_backlog[0].stall;
        in_ch.bus_rdata_in <= req_backlog[0].rdata;
        req_backlog.delete(0);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: ready toggles at random per the current stall rate
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results against the oldest prediction, predicts every taken request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_req_t    r;
    bus_status_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_owed.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = status_owed[0];
          status_owed.delete(0);
          check_field("bus_cyc", 32'(out_ch.bus_cyc), 32'(want.cyc));
          check_field("bus_stb", 32'(out_ch.bus_stb), 32'(want.stb));
          check_field("bus_we", 32'(out_ch.bus_we), 32'(want.we));
          check_field("bus_addr", out_ch.bus_addr, want.addr);
          check_field("bus_wdata", out_ch.bus_wdata, want.wdata);
          check_field("rd_valid", 32'(out_ch.rd_valid), 32'(want.rd_valid));
          check_field("rd_data", out_ch.rd_data, want.rd_data);
          check_field("busy_res", 32'(out_ch.busy_res), 32'(want.busy));
          check_field("cmd_dropped", 32'(out_ch.cmd_dropped), 32'(want.dropped));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        r.req_type  = in_ch.req_type;
        r.cmd_write = in_ch.cmd_write;
        r.cmd_addr  = in_ch.cmd_addr;
        r.cmd_wdata = in_ch.cmd_wdata;
        r.ack       = in_ch.bus_ack_in;
        r.stall     = in_ch.bus_stall_in;
        r.rdata     = in_ch.bus_rdata_in;
        status_owed.insert(status_owed.size(), predict_bus_status(r));
      end
      req_taken <= in_ch.valid && in_ch.ready;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_enqueue(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
    bus_req_t r;
    r = '{default: '0};
    r.req_type  = wpbm_pkg::REQ_ENQUEUE;
    r.cmd_write = wr;
    r.cmd_addr  = addr;
    r.cmd_wdata = wdata;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  task automatic push_tick(logic ack, logic stall, logic [DATA_W-1:0] rdata);
    bus_req_t r;
    r = '{default: '0};
    r.req_type = wpbm_pkg::REQ_TICK;
    r.ack      = ack;
    r.stall    = stall;
    r.rdata    = rdata;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // a request of any kind with every field random, ticks and commands alike
  task automatic push_noise();
    bus_req_t r;
    r.req_type  = 2'($urandom_range(3));
    r.cmd_write = 1'($urandom_range(1));
    r.cmd_addr  = rand_word();
    r.cmd_wdata = rand_word();
    r.ack       = 1'($urandom_range(1));
    r.stall     = 1'($urandom_range(1));
    r.rdata     = rand_word();
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // mostly bursts of commands followed by bus ticks that drain them, with some
  // overfilling bursts and random noise (clears and the unused code among it)
  task automatic gen_bus_traffic(int n_reqs);
    int done;
    int n_cmd;
    int n_tick;
    int pick;
    done = 0;
    while (done < n_reqs) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_noise();
        if (req_backlog[$].req_type != REQ_UNUSED) done++;
      end else begin
        n_cmd  = (pick < 14) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        n_tick = n_cmd * $urandom_range(1, 3) + $urandom_range(0, 3);
        repeat (n_cmd) push_enqueue(1'($urandom_range(1)), rand_word(), rand_word());
        repeat (n_tick)
          push_tick($urandom_range(99) < 60, $urandom_range(99) < 25, rand_word());
        done += n_cmd + n_tick;
      end
    end
  endtask

  // hold off until every request is on the bus and every result has come back
  task automatic wait_drained();
    while (req_backlog.size() > 0 || in_ch.valid || status_owed.size() > 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bus_req_t r;
    rst_n = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = wpbm_pkg::REQ_TICK;
    in_ch.cmd_write    = 1'b0;
    in_ch.cmd_addr     = '0;
    in_ch.cmd_wdata    = '0;
    in_ch.bus_ack_in   = 1'b0;
    in_ch.bus_stall_in = 1'b0;
    in_ch.bus_rdata_in = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    cycle_count    = 0;
    req_taken      = 1'b0;

    // predictor reset state
    cyc_q = 1'b0; stb_q = 1'b0; we_q = 1'b0;
    addr_q = '0; wdata_q = '0;
    cmd_head = 0; cmd_count = 0;
    ack_head = 0; ack_count = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: stray ack out of reset
    push_tick(1'b1, 1'b0, '1);
    // one write and one read at the field extremes
    push_enqueue(1'b1, '1, '0);
    push_enqueue(1'b0, '0, '1);
    push_tick(1'b0, 1'b1, '0);   // present the write
    push_tick(1'b0, 1'b1, '0);   // slave stalls, strobe held
    push_tick(1'b0, 1'b0, '0);   // write taken, read presented
    push_tick(1'b1, 1'b0, '1);   // read taken, write acked
    push_tick(1'b1, 1'b0, '1);   // read acked with all ones, cyc drops
    // clear while a strobe is on the bus, then the strobe taken with an empty queue
    push_enqueue(1'b0, 32'h5a5a_a5a5, 32'h0f0f_f0f0);
    push_tick(1'b0, 1'b0, '0);
    r = '{default: '0};
    r.req_type = wpbm_pkg::REQ_CLEAR;
    req_backlog.insert(req_backlog.size(), r);
    push_tick(1'b1, 1'b0, 32'hdead_beef);
    // unused request code with every field set
    r = '{req_type: REQ_UNUSED, cmd_write: 1'b1, cmd_addr: '1, cmd_wdata: '1,
          ack: 1'b1, stall: 1'b1, rdata: '1};
    req_backlog.insert(req_backlog.size(), r);
    // fill the queue and push one past it
    repeat (QDEPTH + 1) push_enqueue(1'($urandom_range(1)), ADDR_W'($urandom), DATA_W'($urandom));
    r = '{default: '0};
    r.req_type = wpbm_pkg::REQ_CLEAR;
    req_backlog.insert(req_backlog.size(), r);
    wait_drained();

    // random phases, each drained before the next so the sender sits idle in between
    send_idle_pct = 0;  recv_stall_pct = 0;
    gen_bus_traffic(490);
    wait_drained();
    send_idle_pct = 58; recv_stall_pct = 0;
    gen_bus_traffic(490);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 58;
    gen_bus_traffic(490);
    wait_drained();
    send_idle_pct = 13; recv_stall_pct = 13;
    gen_bus_traffic(490);
    wait_drained();

    // let any stray result show up before the verdict
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && status_owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
